>>> hw/rtl/srlc_pkg.sv
package srlc_pkg;

	// Character codes the checker looks for
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_EXP   = 8'h45;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_INVALID  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	// Limits of the saturating counters
	localparam logic [1:0] SMALL_CNT_TOP = 2'd2;
	localparam logic [5:0] MANT_CNT_TOP  = 6'd63;

	// Register reset value
	localparam logic [5:0] MAX_MANT_RESET = 6'd30;

	// Per-literal scan state
	typedef struct packed {
		logic       in_body;
		logic       sign_missing;
		logic [7:0] prev_char;
		logic [1:0] exp_marks;
		logic [1:0] dot_count;
		logic [5:0] mantissa_digits;
		logic [1:0] exp_chars;
		logic       body_error;
	} lit_state_t;

endpackage

>>> hw/rtl/srlc_step.sv
module srlc_step
	import srlc_pkg::*;
(
	input  lit_state_t cur,
	input  logic [7:0] ch,
	input  logic       is_last,
	input  logic [5:0] max_mantissa_digits,
	output lit_state_t nxt,
	output logic [1:0] status
);

	lit_state_t upd;
	logic       is_digit;
	logic       is_sign;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

	// Advance the scan state by one character
	always_comb begin
		upd = cur;
		if (!cur.in_body) begin
			if (!is_sign) begin
				upd.sign_missing = 1'b1;
			end
			upd.in_body = 1'b1;
		end else if (!cur.sign_missing && !cur.body_error) begin
			priority if (ch == CH_EXP) begin
				if (cur.exp_marks != SMALL_CNT_TOP) begin
					upd.exp_marks = cur.exp_marks + 2'd1;
				end
			end else if (ch == CH_DOT && cur.exp_marks != 2'd0) begin
				upd.body_error = 1'b1;
			end else if (ch == CH_DOT) begin
				if (cur.dot_count != SMALL_CNT_TOP) begin
					upd.dot_count = cur.dot_count + 2'd1;
				end
			end else if (is_sign && cur.prev_char != CH_EXP && !is_last) begin
				upd.body_error = 1'b1;
			end else if (!is_digit && !is_sign) begin
				upd.body_error = 1'b1;
			end else if (cur.exp_marks == 2'd0 && is_digit) begin
				if (cur.mantissa_digits != MANT_CNT_TOP) begin
					upd.mantissa_digits = cur.mantissa_digits + 6'd1;
				end
			end else if (cur.exp_marks == 2'd1) begin
				if (cur.exp_chars != SMALL_CNT_TOP) begin
					upd.exp_chars = cur.exp_chars + 2'd1;
				end
			end else begin
				upd = upd;
			end
		end
		upd.prev_char = ch;
	end

	// Grade the literal, first match wins
	always_comb begin
		priority if (upd.mantissa_digits == 6'd0 && upd.dot_count != 2'd0) begin
			status = STATUS_INVALID;
		end else if (upd.dot_count == 2'd0 && upd.mantissa_digits == 6'd0 &&
				upd.exp_chars <= 2'd1) begin
			status = STATUS_INVALID;
		end else if (upd.dot_count > 2'd1 || upd.exp_marks > 2'd1) begin
			status = STATUS_INVALID;
		end else if (upd.mantissa_digits > max_mantissa_digits) begin
			status = STATUS_TOO_LONG;
		end else if (upd.sign_missing || upd.body_error) begin
			status = STATUS_INVALID;
		end else begin
			status = STATUS_OK;
		end
	end

	// Drop the state once the literal ends
	assign nxt = is_last ? lit_state_t'('0) : upd;

endmodule

>>> hw/rtl/signed_real_literal_checker_core.sv
// Signed real-literal checker.
// Input channel (in_valid/in_ready, ch, is_last) takes one character per
// request; the first character of a literal is its sign, and is_last marks
// the final one. Output channel (out_valid/out_ready, status) gives one
// status request per literal, on its last character: 0 ok, 1 invalid,
// 2 too many mantissa digits. Characters without is_last give no output.
// Configuration: cfg_we writes cfg_wdata into max_mantissa_digits at the
// clock edge; write it only while no literal is in flight.
// Timing: a character is registered at acceptance and, once the output
// register is free, graded into it, so status is presented from the output
// register. One character per cycle is sustained while out_ready keeps
// up; the single input and single output register set that rate.
// When out_ready is low with a status waiting, the input register may
// still fill, and in_ready drops only while both registers are held.
// Reset (arst_n low) clears the scan state, empties both registers and
// sets max_mantissa_digits to 30.
module signed_real_literal_checker_core
	import srlc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);

	logic [5:0] max_mant_q;
	lit_state_t state_q;
	lit_state_t state_nxt;
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [1:0] status_nxt;
	logic       adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Hold the mantissa limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mant_q <= MAX_MANT_RESET;
		end else if (cfg_we) begin
			max_mant_q <= cfg_wdata;
		end
	end

	// Capture the incoming character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= is_last;
		end
	end

	srlc_step u_step (
		.cur                 (state_q),
		.ch                  (ch_s1),
		.is_last             (last_s1),
		.max_mantissa_digits (max_mant_q),
		.nxt                 (state_nxt),
		.status              (status_nxt)
	);

	// Advance the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Load or release the status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= last_s1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q <= status_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	// Checks
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == STATUS_OK || status_q == STATUS_INVALID ||
			status_q == STATUS_TOO_LONG))
		else $error("status code out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without both registers held");

	a_last_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> out_valid_q)
		else $error("last character gave no status");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (state_q == lit_state_t'('0)))
		else $error("scan state not cleared after literal");

endmodule

>>> bench/signed_real_literal_checker_core_tb.sv
`timescale 1ns / 100ps

module signed_real_literal_checker_core_tb;
	import srlc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int CHARS_PER_PHASE = 320;
	localparam int NUM_PHASES = 6;

	// Tracks scan state per literal and holds the status each literal must produce
	class literal_scoreboard;
		logic [5:0] max_digits = MAX_MANT_RESET;
		lit_state_t scan = '0;
		logic [1:0] status_q[$];
		int n_fail = 0;
		int n_checked = 0;
		int n_ok = 0;
		int n_invalid = 0;
		int n_too_long = 0;

		function void set_limit(logic [5:0] v);
			max_digits = v;
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		// Advance the counters for one character of the body
		function void scan_body(logic [7:0] c, logic last);
			logic is_digit;
			logic is_sign;
			is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
			is_sign = (c == CH_PLUS) || (c == CH_MINUS);
			if (c == CH_EXP) begin
				if (scan.exp_marks != SMALL_CNT_TOP)
					scan.exp_marks++;
			end else if (c == CH_DOT && scan.exp_marks != 0) begin
				scan.body_error = 1'b1;
			end else if (c == CH_DOT) begin
				if (scan.dot_count != SMALL_CNT_TOP)
					scan.dot_count++;
			end else if (is_sign && scan.prev_char != CH_EXP && !last) begin
				scan.body_error = 1'b1;
			end else if (!is_digit && !is_sign) begin
				scan.body_error = 1'b1;
			end else if (scan.exp_marks == 0 && is_digit) begin
				if (scan.mantissa_digits != MANT_CNT_TOP)
					scan.mantissa_digits++;
			end else if (scan.exp_marks == 1) begin
				if (scan.exp_chars != SMALL_CNT_TOP)
					scan.exp_chars++;
			end
		endfunction

		// Grade the finished literal; earlier checks override later ones
		function logic [1:0] grade();
			logic [1:0] exp_tail;
			exp_tail = (scan.exp_chars != 0) ? scan.exp_chars - 2'd1 : 2'd0;
			if (scan.mantissa_digits == 0 && scan.dot_count != 0)
				return STATUS_INVALID;
			if (scan.dot_count == 0 && scan.mantissa_digits == 0 && exp_tail == 0)
				return STATUS_INVALID;
			if (scan.dot_count > 1 || scan.exp_marks > 1)
				return STATUS_INVALID;
			if (scan.mantissa_digits > max_digits)
				return STATUS_TOO_LONG;
			if (scan.sign_missing || scan.body_error)
				return STATUS_INVALID;
			return STATUS_OK;
		endfunction

		// Note an accepted character request
		function void note_char(logic [7:0] c, logic last);
			if (!scan.in_body) begin
				if (c != CH_PLUS && c != CH_MINUS)
					scan.sign_missing = 1'b1;
				scan.in_body = 1'b1;
			end else if (!scan.sign_missing && !scan.body_error) begin
				scan_body(c, last);
			end
			scan.prev_char = c;
			if (last) begin
				status_q.push_back(grade());
				scan = '0;
			end
		endfunction

		// Compare an accepted status request with the oldest expectation
		function void check_status(logic [1:0] got);
			logic [1:0] want;
			if (status_q.size() == 0) begin
				$display("%0t: status %0d with no literal pending", $time, got);
				n_fail++;
				return;
			end
			want = status_q.pop_front();
			n_checked++;
			case (want)
				STATUS_OK: n_ok++;
				STATUS_INVALID: n_invalid++;
				default: n_too_long++;
			endcase
			if (got !== want) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, want, got);
				n_fail++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] ch;
	logic is_last;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic cfg_we;
	logic [5:0] cfg_wdata;

	literal_scoreboard board;
	logic [7:0] lit_chars[$];
	bit quiet;
	int cycle_count;
	int n_chars_sent;
	int phase_chars;

	signed_real_literal_checker_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none at all in the quiet phase
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Drive one character request and wait for its acceptance
	task automatic send_char(logic [7:0] c, logic last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		board.note_char(c, last);
	endtask

	task automatic send_literal();
		for (int i = 0; i < lit_chars.size(); i++)
			send_char(lit_chars[i], i == lit_chars.size() - 1);
		n_chars_sent += lit_chars.size();
		phase_chars += lit_chars.size();
		lit_chars.delete();
	endtask

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			lit_chars.push_back(s[i]);
	endfunction

	function automatic void push_digits(int n);
		for (int i = 0; i < n; i++)
			lit_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// Build one literal: mostly well formed, some corrupted, some pure noise
	function automatic void build_random_literal();
		int kind;
		int n_mant;
		int dot_pos;
		int pos;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8))
				lit_chars.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 9) != 0)
			lit_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		else
			lit_chars.push_back(8'($urandom_range(0, 255)));
		kind = $urandom_range(0, 99);
		if (kind < 75)
			n_mant = $urandom_range(0, 6);
		else if (kind < 95)
			n_mant = $urandom_range(7, 40);
		else
			n_mant = $urandom_range(55, 70);
		dot_pos = $urandom_range(0, 1) ? $urandom_range(0, n_mant) : -1;
		for (int i = 0; i <= n_mant; i++) begin
			if (i == dot_pos)
				lit_chars.push_back(CH_DOT);
			if (i < n_mant)
				push_digits(1);
		end
		if ($urandom_range(0, 9) < 4) begin
			lit_chars.push_back(CH_EXP);
			if ($urandom_range(0, 1))
				lit_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			push_digits($urandom_range(0, 4));
		end
		if ($urandom_range(0, 9) == 0)
			lit_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		// Corrupt a few: overwrite or insert a troublesome character
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 4))
				0: c = CH_DOT;
				1: c = CH_EXP;
				2: c = CH_PLUS;
				3: c = CH_MINUS;
				default: c = 8'($urandom_range(0, 255));
			endcase
			pos = $urandom_range(0, lit_chars.size() - 1);
			if ($urandom_range(0, 1))
				lit_chars.insert(pos, c);
			else
				lit_chars[pos] = c;
		end
	endfunction

	// Drop valid and wait until every status has come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [5:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_limit(v);
	endtask

	// Receiver: random stalls on the status channel
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
	end

	// Check each accepted status request
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_status(status);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[signed_real_literal_checker_core] ERROR");
			$finish;
		end
	end

	initial begin
		logic [5:0] limits[NUM_PHASES];
		board = new;
		cycle_count = 0;
		n_chars_sent = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = 8'h00;
		is_last = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 6'd0;
		limits = '{6'd1, 6'd62, 6'd63, 6'd0, 6'($urandom_range(2, 61)), MAX_MANT_RESET};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			quiet = (ph == 2);
			phase_chars = 0;
			write_limit(limits[ph]);
			if (ph == 0) begin
				// Lone sign, then a digit that fits a limit of one
				push_text("+");
				send_literal();
				push_text("-0");
				send_literal();
				// One digit too many for a limit of one
				push_text("+12");
				send_literal();
				// Dot with no digits, second dot, dot after the exponent mark
				push_text("+.");
				send_literal();
				push_text("+1..");
				send_literal();
				push_text("+E.");
				send_literal();
				// Sign in the middle, sign as final character
				push_text("+1+2");
				send_literal();
				push_text("+1-");
				send_literal();
				// All-ones character without a sign, and the zero character
				lit_chars.push_back(8'hFF);
				send_literal();
				lit_chars.push_back(CH_PLUS);
				lit_chars.push_back(8'h00);
				send_literal();
			end
			while (phase_chars < CHARS_PER_PHASE) begin
				build_random_literal();
				send_literal();
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("sent %0d characters, checked %0d literals: %0d ok, %0d invalid, %0d too long",
			n_chars_sent, board.n_checked, board.n_ok, board.n_invalid, board.n_too_long);
		$display("digit limits used: %0d %0d %0d %0d %0d %0d",
			limits[0], limits[1], limits[2], limits[3], limits[4], limits[5]);
		if (board.n_fail == 0 && board.pending() == 0) begin
			$display("[signed_real_literal_checker_core] OK");
		end else begin
			$display("%0d failures, %0d statuses missing", board.n_fail, board.pending());
			$display("[signed_real_literal_checker_core] ERROR");
		end
		$finish;
	end

endmodule
